// ===== hw/rtl/pfm_pkg.sv =====
// shared types and constants for the pump fault monitor
`default_nettype none

package pfm_pkg;

  localparam int unsigned CNT16_W  = 16;
  localparam int unsigned CNT20_W  = 20;
  localparam int unsigned PRESS_W  = 16;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_LEAK  = 2'd2,
    ERR_BLOCK = 2'd3
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAK_TIMEOUT     = 2'd0,
    REG_RECORD_PERIOD    = 2'd1,
    REG_BLOCKAGE_ARM     = 2'd2,
    REG_LIQUID_THRESHOLD = 2'd3
  } cfg_reg_t;

  localparam logic [CNT16_W-1:0] LEAK_TIMEOUT_RST     = 16'd3000;
  localparam logic [CNT16_W-1:0] RECORD_PERIOD_RST    = 16'd3000;
  localparam logic [CNT20_W-1:0] BLOCKAGE_ARM_RST     = CNT20_W'(3000 * 8);
  localparam logic [LEVEL_W-1:0] LIQUID_THRESHOLD_RST = 12'd150;

  localparam logic [CNT16_W-1:0] CNT16_MAX = '1;
  localparam logic [CNT20_W-1:0] CNT20_MAX = '1;

  typedef struct packed {
    logic [CNT16_W-1:0] leak_timeout;
    logic [CNT16_W-1:0] record_period;
    logic [CNT20_W-1:0] blockage_arm;
    logic [LEVEL_W-1:0] liquid_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pump_fault_monitor_core.sv =====
// Pump fault monitor: one result word per input word, one word per clock
// sustained while the output side is ready. A word enters an input register,
// its fault checks (liquid full, leakage, blockage, in that order) and all
// timer and flag updates are done by short logic as it leaves that register,
// and the result lands in an output register, so the block takes a new word
// every cycle while the output side is ready. The history ring holds HISTORY_DEPTH
// pressure samples in flip-flops and is compared in parallel. Configuration writes
// are registered and should be issued only while no word is in flight.
`default_nettype none

module pump_fault_monitor_core #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  // input words
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire                            kind,
  input  wire                            pump_on,
  input  wire [pfm_pkg::PRESS_W-1:0]     pressure,
  input  wire [pfm_pkg::LEVEL_W-1:0]     level_sample,
  input  wire [1:0]                      clear_code,
  // result words
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [1:0]                     fault_code,
  output logic                           leak_flag,
  output logic                           block_flag,
  output logic                           full_flag,
  // configuration writes
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [pfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pfm_pkg::*;

  cfg_t cfg;

  // input register
  logic               s1_valid;
  logic               s1_kind;
  logic               s1_pump_on;
  logic [PRESS_W-1:0] s1_pressure;
  logic [LEVEL_W-1:0] s1_level;
  logic [1:0]         s1_code;

  // monitor state
  logic [CNT16_W-1:0] leak_count;
  logic [CNT20_W-1:0] block_count;
  logic [CNT16_W-1:0] interval_count;
  err_code_t          err_state;
  logic               flag_full;
  logic               flag_leak;
  logic               flag_block;

  logic [CNT16_W-1:0] leak_count_next;
  logic [CNT20_W-1:0] block_count_next;
  logic [CNT16_W-1:0] interval_count_next;
  err_code_t          err_state_next;
  logic               flag_full_next;
  logic               flag_leak_next;
  logic               flag_block_next;

  logic out_free;
  logic step_en;
  logic ring_wr;
  logic ring_same;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign step_en   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;

  pfm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pfm_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (ring_wr),
    .wr_data      (s1_pressure),
    .same_nonzero (ring_same)
  );

  always_comb begin
    logic stop;
    logic record;
    stop                = 1'b0;
    record              = 1'b0;
    leak_count_next     = leak_count;
    block_count_next    = block_count;
    interval_count_next = interval_count;
    err_state_next      = err_state;
    flag_full_next      = flag_full;
    flag_leak_next      = flag_leak;
    flag_block_next     = flag_block;

    if (!s1_kind) begin
      if (s1_level < cfg.liquid_threshold) begin
        flag_full_next = 1'b1;
        err_state_next = ERR_FULL;
      end else begin
        if (s1_pump_on) begin
          leak_count_next = (leak_count != CNT16_MAX) ? leak_count + CNT16_W'(1) : leak_count;
          // compare uses the timer value before this tick's increment
          if (leak_count > cfg.leak_timeout) begin
            flag_leak_next = 1'b1;
            err_state_next = ERR_LEAK;
            stop           = 1'b1;
          end
        end else begin
          leak_count_next = '0;
        end

        if (!stop) begin
          if (interval_count >= cfg.record_period) begin
            interval_count_next = '0;
            record              = 1'b1;
            if (block_count > cfg.blockage_arm && ring_same) begin
              flag_block_next = 1'b1;
              err_state_next  = ERR_BLOCK;
              stop            = 1'b1;
            end
          end else begin
            interval_count_next = (interval_count != CNT16_MAX) ?
                                  interval_count + CNT16_W'(1) : interval_count;
          end
          if (!stop) begin
            block_count_next = (block_count != CNT20_MAX) ?
                               block_count + CNT20_W'(1) : block_count;
            err_state_next   = ERR_NONE;
          end
        end
      end
    end else if (err_state == err_code_t'(s1_code)) begin
      err_state_next = ERR_NONE;
      unique case (err_code_t'(s1_code))
        ERR_NONE: ;
        ERR_FULL: flag_full_next = 1'b0;
        ERR_LEAK: begin
          flag_leak_next  = 1'b0;
          leak_count_next = '0;
        end
        ERR_BLOCK: begin
          flag_block_next  = 1'b0;
          block_count_next = '0;
        end
        default: ;
      endcase
    end

    ring_wr = step_en && record;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      leak_count     <= '0;
      block_count    <= '0;
      interval_count <= '0;
      err_state      <= ERR_NONE;
      flag_full      <= 1'b0;
      flag_leak      <= 1'b0;
      flag_block     <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (step_en) begin
        leak_count     <= leak_count_next;
        block_count    <= block_count_next;
        interval_count <= interval_count_next;
        err_state      <= err_state_next;
        flag_full      <= flag_full_next;
        flag_leak      <= flag_leak_next;
        flag_block     <= flag_block_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind     <= kind;
      s1_pump_on  <= pump_on;
      s1_pressure <= pressure;
      s1_level    <= level_sample;
      s1_code     <= clear_code;
    end
    if (step_en) begin
      fault_code <= err_state_next;
      leak_flag  <= flag_leak_next;
      block_flag <= flag_block_next;
      full_flag  <= flag_full_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfm_cfg_regs.sv =====
// configuration register file of the pump fault monitor
`default_nettype none

module pfm_cfg_regs (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            wr_en,
  input  wire [pfm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire [pfm_pkg::CFG_DATA_W-1:0]  wr_data,
  output pfm_pkg::cfg_t                  cfg
);
  import pfm_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leak_timeout     <= LEAK_TIMEOUT_RST;
      regs.record_period    <= RECORD_PERIOD_RST;
      regs.blockage_arm     <= BLOCKAGE_ARM_RST;
      regs.liquid_threshold <= LIQUID_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_LEAK_TIMEOUT:     regs.leak_timeout     <= wr_data[CNT16_W-1:0];
        REG_RECORD_PERIOD:    regs.record_period    <= wr_data[CNT16_W-1:0];
        REG_BLOCKAGE_ARM:     regs.blockage_arm     <= wr_data[CNT20_W-1:0];
        REG_LIQUID_THRESHOLD: regs.liquid_threshold <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ===== hw/rtl/pfm_ring.sv =====
// pressure history ring with all-equal-and-nonzero check
`default_nettype none

module pfm_ring #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          wr_en,
  input  wire [pfm_pkg::PRESS_W-1:0]   wr_data,
  output logic                         same_nonzero
);
  import pfm_pkg::*;

  localparam int unsigned POS_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);

  logic [PRESS_W-1:0] ring [HISTORY_DEPTH];
  logic [POS_W-1:0]   pos;
  logic [PRESS_W-1:0] view [HISTORY_DEPTH];

  // contents as they stand after the incoming sample is written
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      view[i] = (pos == POS_W'(i)) ? wr_data : ring[i];
    end
  end

  always_comb begin
    same_nonzero = (view[0] != '0);
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      if (view[i] != view[0]) begin
        same_nonzero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (wr_en) begin
      ring[pos] <= wr_data;
      pos       <= (pos == LAST_POS) ? '0 : pos + POS_W'(1);
    end
  end

endmodule

`default_nettype wire
